@@ hdl/smas_pkg.sv @@
// Shared types and constants for the stroke moving-average smoother.
`default_nettype none

package smas_pkg;

   localparam int DEF_MAX_HALF_WINDOW = 7;
   localparam int DEF_COORD_WIDTH     = 16;

   localparam int       HALF_WINDOW_W     = 3;
   localparam int       CSR_DATA_W        = 8;
   localparam logic [HALF_WINDOW_W-1:0] HALF_WINDOW_RESET = 3'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLAN,
      ST_SUM,
      ST_DRAIN,
      ST_DIVX_GO,
      ST_DIVX_WAIT,
      ST_DIVY_GO,
      ST_DIVY_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SRC_MEM,
      SRC_NEWEST,
      SRC_FIRST
   } src_type;

   typedef struct packed {
      logic req_ready;
      logic acc_clear;
      logic sum_issue;
      logic div_start;
      logic div_sel_y;
      logic emit;
   } ctrl_type;

endpackage

`default_nettype wire

@@ hdl/smas_div.sv @@
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module smas_div #(
   parameter int SUM_W = 20,
   parameter int DIV_W = 5,
   parameter int QUO_W = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  wire signed [SUM_W-1:0]  dividend,
   input  wire        [DIV_W-1:0]  divisor,
   output logic                    done,
   output logic signed [QUO_W-1:0] quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   dsr_ff, dsr_in;
   logic               neg_ff, neg_in;
   logic [DIV_W:0]     trial;
   logic               fits;
   logic [SUM_W-1:0]   signed_quo;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W);
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? (-dividend) : dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(trial - {1'b0, dsr_ff}) : DIV_W'(trial);
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign signed_quo = neg_ff ? (-quo_ff) : quo_ff;
   assign done       = done_ff;
   assign quotient   = signed_quo[QUO_W-1:0];

endmodule

`default_nettype wire

@@ hdl/stroke_moving_average_smoother.sv @@
// Top level of the stroke moving-average smoother.
//
// Pen points enter on the req_ stream (x, y in tdata, pen flag in tuser,
// stroke end in tlast); smoothed points leave on the rsp_ stream in the same
// layout. csr_ writes the half window k (3 bits), latched at each stroke's
// first point and clamped to MAX_HALF_WINDOW.
// One request is taken at a time: req_tready is high only while idle.
// Each result sums its 2k+1 window terms, one history read per term, after
// a planning step for the first result of a request; then x and y take two
// passes through the shared divider of COORD_WIDTH+clog2(2*MAX_HALF_WINDOW+1)
// quotient bits, and the result is loaded into the output register.
// A request that owes no result returns the sequencer to idle after its
// planning step; a stroke end flushes up to k+1 results, oldest first.
// The output register holds a result until rsp_tready; a stalled receiver
// holds the sequencer before it loads the next result, while the input side
// keeps accepting once the sequencer is idle.
// Synchronous reset clears the stroke state and sets k to 1; the history
// memory needs no clearing since only points of the current stroke are read.
`default_nettype none

module stroke_moving_average_smoother
   import smas_pkg::*;
#(
   parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
   parameter int COORD_WIDTH     = DEF_COORD_WIDTH
) (
   input  wire                             clock,
   input  wire                             reset,
   // tdata: pos_x, pos_y
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // tuser: pen_is_down
   input  wire                             req_tuser,
   input  wire                             req_tlast,
   // tdata: smooth_x, smooth_y
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // tuser: out_pen_down
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   // data: half_window
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [CSR_DATA_W-1:0]           csr_data
);

   localparam int DATA_W = ((2*COORD_WIDTH+7)/8)*8;
   localparam int DEPTH  = 2*MAX_HALF_WINDOW + 1;
   localparam int AW     = $clog2(DEPTH);
   localparam int SEEN_W = $clog2(DEPTH + 1);
   localparam int SUM_W  = COORD_WIDTH + $clog2(DEPTH);
   localparam int CW     = COORD_WIDTH;

   state_type state_ff, state_in;
   ctrl_type  ctrl;

   logic [HALF_WINDOW_W-1:0] half_window_ff;
   logic [AW-1:0]            k_clamped;
   logic [AW-1:0]            k_ff;
   logic                     pen_ff;
   logic signed [CW-1:0]     first_x_ff, first_y_ff;
   logic signed [CW-1:0]     new_x_ff, new_y_ff;
   logic [SEEN_W-1:0]        seen_ff, seen_in;
   logic [AW-1:0]            newest_idx_ff, newest_idx_in;
   logic [AW-1:0]            newest_addr_ff;
   logic [AW-1:0]            wptr_ff, wptr_in;
   logic                     end_ff;
   logic [AW-1:0]            m_ff, m_in;
   logic [AW-1:0]            t_ff, t_in;
   logic                     req_take;

   logic signed [CW-1:0]     in_x, in_y;

   logic [2*CW-1:0]          mem [DEPTH];
   logic [2*CW-1:0]          mem_q_ff;
   logic [AW-1:0]            rd_addr;
   logic [AW-1:0]            mk;
   logic signed [AW:0]       off_s;
   logic [AW-1:0]            off;
   logic [AW:0]              addr_diff;
   src_type                  src;
   src_type                  sel_ff;
   logic                     rd_valid_ff;

   logic signed [CW-1:0]     op_x, op_y;
   logic signed [SUM_W-1:0]  acc_x_ff, acc_y_ff;

   logic                     div_done;
   logic signed [CW-1:0]     div_q;
   logic signed [CW-1:0]     qx_ff;
   logic [AW:0]              divisor;

   logic                     rsp_valid_ff;
   logic signed [CW-1:0]     rsp_x_ff, rsp_y_ff;
   logic                     rsp_pen_ff, rsp_last_ff;
   logic                     rsp_free;
   logic                     last_term;

   assign in_x     = req_tdata[CW-1:0];
   assign in_y     = req_tdata[2*CW-1:CW];
   assign req_take = req_tvalid && ctrl.req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign last_term = (t_ff == AW'({k_ff, 1'b0}));

   assign k_clamped = (int'(half_window_ff) > MAX_HALF_WINDOW) ?
                      AW'(MAX_HALF_WINDOW) : AW'(half_window_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (end_ff || (newest_idx_ff >= k_ff)) begin
               state_in = ST_SUM;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SUM: begin
            if (last_term) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:     state_in = ST_DIVX_GO;
         ST_DIVX_GO:   state_in = ST_DIVX_WAIT;
         ST_DIVX_WAIT: begin
            if (div_done) begin
               state_in = ST_DIVY_GO;
            end
         end
         ST_DIVY_GO:   state_in = ST_DIVY_WAIT;
         ST_DIVY_WAIT: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               if (end_ff && (m_ff != '0)) begin
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE:    ctrl.req_ready = 1'b1;
         ST_PLAN:    ctrl.acc_clear = 1'b1;
         ST_SUM:     ctrl.sum_issue = 1'b1;
         ST_DIVX_GO: ctrl.div_start = 1'b1;
         ST_DIVY_GO: begin
            ctrl.div_start = 1'b1;
            ctrl.div_sel_y = 1'b1;
         end
         ST_EMIT: begin
            ctrl.emit      = rsp_free;
            ctrl.acc_clear = rsp_free;
         end
         default:    ctrl = '0;
      endcase
   end

   // stroke bookkeeping
   always_comb begin
      seen_in       = seen_ff;
      newest_idx_in = newest_idx_ff;
      wptr_in       = wptr_ff;
      if (req_take) begin
         if (seen_ff == SEEN_W'(DEPTH)) begin
            newest_idx_in = AW'(DEPTH - 1);
         end else begin
            newest_idx_in = AW'(seen_ff);
            seen_in       = seen_ff + 1'b1;
         end
         if (req_tlast) begin
            seen_in = '0;
         end
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
   end

   always_comb begin
      m_in = m_ff;
      t_in = t_ff;
      if (state_ff == ST_PLAN) begin
         m_in = (end_ff && (newest_idx_ff < k_ff)) ? newest_idx_ff : k_ff;
      end else if (ctrl.emit) begin
         m_in = m_ff - 1'b1;
      end
      if (ctrl.acc_clear) begin
         t_in = '0;
      end else if (ctrl.sum_issue) begin
         t_in = t_ff + 1'b1;
      end
   end

   // window term selection
   assign mk        = m_ff + k_ff;
   assign off_s     = $signed({1'b0, mk}) - $signed({1'b0, t_ff});
   assign off       = off_s[AW-1:0];
   assign addr_diff = {1'b0, newest_addr_ff} - {1'b0, off};
   assign rd_addr   = addr_diff[AW] ? AW'(addr_diff + (AW+1)'(DEPTH)) : addr_diff[AW-1:0];

   always_comb begin
      if (off_s[AW]) begin
         src = SRC_NEWEST;
      end else if (off > newest_idx_ff) begin
         src = SRC_FIRST;
      end else begin
         src = SRC_MEM;
      end
   end

   always_comb begin
      case (sel_ff)
         SRC_NEWEST: begin
            op_x = new_x_ff;
            op_y = new_y_ff;
         end
         SRC_FIRST: begin
            op_x = first_x_ff;
            op_y = first_y_ff;
         end
         default: begin
            op_x = mem_q_ff[CW-1:0];
            op_y = mem_q_ff[2*CW-1:CW];
         end
      endcase
   end

   // history memory
   always_ff @(posedge clock) begin
      if (req_take) begin
         mem[wptr_ff] <= {in_y, in_x};
      end
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         half_window_ff <= HALF_WINDOW_RESET;
         seen_ff        <= '0;
         wptr_ff        <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         seen_ff     <= seen_in;
         wptr_ff     <= wptr_in;
         rd_valid_ff <= ctrl.sum_issue;
         if (csr_valid) begin
            half_window_ff <= csr_data[HALF_WINDOW_W-1:0];
         end
         if (ctrl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      newest_idx_ff <= newest_idx_in;
      m_ff          <= m_in;
      t_ff          <= t_in;
      sel_ff        <= src;
      if (req_take) begin
         newest_addr_ff <= wptr_ff;
         new_x_ff       <= in_x;
         new_y_ff       <= in_y;
         end_ff         <= req_tlast;
         if (seen_ff == '0) begin
            k_ff       <= k_clamped;
            pen_ff     <= req_tuser;
            first_x_ff <= in_x;
            first_y_ff <= in_y;
         end
      end
      if (ctrl.acc_clear) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (rd_valid_ff) begin
         acc_x_ff <= acc_x_ff + SUM_W'(op_x);
         acc_y_ff <= acc_y_ff + SUM_W'(op_y);
      end
      if ((state_ff == ST_DIVX_WAIT) && div_done) begin
         qx_ff <= div_q;
      end
      if (ctrl.emit) begin
         rsp_x_ff    <= qx_ff;
         rsp_y_ff    <= div_q;
         rsp_pen_ff  <= pen_ff;
         rsp_last_ff <= end_ff && (m_ff == '0);
      end
   end

   assign divisor = {k_ff, 1'b1};

   smas_div #(
      .SUM_W (SUM_W),
      .DIV_W (AW + 1),
      .QUO_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (ctrl.div_sel_y ? acc_y_ff : acc_x_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_tready = ctrl.req_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'({rsp_y_ff, rsp_x_ff});
   assign rsp_tuser  = rsp_pen_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_ready  = 1'b1;

endmodule

`default_nettype wire

@@ hdl/smas_checker.sv @@
// Port-level assertions for the stroke moving-average smoother, bound to the top level.
`default_nettype none

module smas_checker #(
   parameter int DATA_W = 32
) (
   input wire              clock,
   input wire              reset,
   input wire              req_tvalid,
   input wire              req_tready,
   input wire              rsp_tvalid,
   input wire              rsp_tready,
   input wire [DATA_W-1:0] rsp_tdata,
   input wire              rsp_tuser,
   input wire              rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("result changed while stalled");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while busy");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("not idle after reset");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result appeared right after request");

endmodule

bind stroke_moving_average_smoother smas_checker #(
   .DATA_W (DATA_W)
) u_smas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
